// ----- src/rept_pkg.sv -----
// shared constants, register map and types for the rotary encoder position tracker
// used by every module in src; no dependencies of its own
`default_nettype none

package rept_pkg;

  // widths of the counting and filtering datapath and the edges per detent
  localparam int COUNT_WIDTH      = 16;
  localparam int FILTER_WIDTH     = 10;
  localparam int EDGES_PER_DETENT = 4;

  // field and register widths
  localparam int POS_WIDTH   = 16;
  localparam int STEP_WIDTH  = 15;
  localparam int ID_WIDTH    = 8;
  localparam int DATA_WIDTH  = 32;
  localparam int ADDR_WIDTH  = 5;
  localparam int IN_WIDTH    = 8;
  localparam int OUT_WIDTH   = 24;

  // register indexes on the configuration port (byte address is 4 * index)
  typedef enum logic [2:0] {
    REG_MIN_POSITION   = 3'd0,
    REG_MAX_POSITION   = 3'd1,
    REG_STEP_SIZE      = 3'd2,
    REG_WRAP_ENABLE    = 3'd3,
    REG_GLITCH_TICKS   = 3'd4,
    REG_ENCODER_ID     = 3'd5,
    REG_START_POSITION = 3'd6
  } reg_idx_t;

  // register reset values
  localparam logic signed [POS_WIDTH-1:0] MIN_POSITION_RST   = 16'sd0;
  localparam logic signed [POS_WIDTH-1:0] MAX_POSITION_RST   = 16'sd100;
  localparam logic [STEP_WIDTH-1:0]       STEP_SIZE_RST      = 15'd1;
  localparam logic                        WRAP_ENABLE_RST    = 1'b0;
  localparam logic [FILTER_WIDTH-1:0]     GLITCH_TICKS_RST   = '0;
  localparam logic [ID_WIDTH-1:0]         ENCODER_ID_RST     = '0;
  localparam logic signed [POS_WIDTH-1:0] START_POSITION_RST = 16'sd0;

  // filtered level of one pin before and after the current sample
  typedef struct packed {
    logic level_old;
    logic level_new;
  } pin_edge_t;

  // detent movement decided for the current sample
  typedef struct packed {
    logic move;
    logic up;
  } detent_move_t;

  // position limits and stepping controls
  typedef struct packed {
    logic signed [POS_WIDTH-1:0] min_pos;
    logic signed [POS_WIDTH-1:0] max_pos;
    logic [STEP_WIDTH-1:0]       step;
    logic                        wrap;
  } pos_cfg_t;

endpackage

`default_nettype wire

// ----- src/rept_glitch_filter.sv -----
// glitch filter for one encoder pin: a new level is taken once it has held long enough
// depends on rept_pkg
`default_nettype none

module rept_glitch_filter (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              en,
  input  wire logic                              sample,
  input  wire logic [rept_pkg::FILTER_WIDTH-1:0] glitch_ticks,
  output rept_pkg::pin_edge_t                    pin
);
  import rept_pkg::*;

  logic                    level;
  logic                    level_next;
  logic [FILTER_WIDTH-1:0] hold;
  logic [FILTER_WIDTH-1:0] hold_next;

  // hold count runs while the sample disagrees, saturating at all ones
  always_comb begin
    level_next = level;
    hold_next  = hold;
    if (sample == level) begin
      hold_next = '0;
    end else if (hold >= glitch_ticks) begin
      level_next = sample;
      hold_next  = '0;
    end else if (hold != '1) begin
      hold_next = hold + 1'b1;
    end
  end

  // pull-up idle level after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      level <= 1'b1;
      hold  <= '0;
    end else if (en) begin
      level <= level_next;
      hold  <= hold_next;
    end
  end

  assign pin.level_old = level;
  assign pin.level_new = level_next;

endmodule

`default_nettype wire

// ----- src/rept_quad_counter.sv -----
// x4 quadrature edge counter with detent change detection
// depends on rept_pkg
`default_nettype none

module rept_quad_counter (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  rept_pkg::pin_edge_t pin_a,
  input  rept_pkg::pin_edge_t pin_b,
  output rept_pkg::detent_move_t mv
);
  import rept_pkg::*;

  logic signed [COUNT_WIDTH-1:0] count;
  logic signed [COUNT_WIDTH-1:0] count_next;
  logic signed [COUNT_WIDTH-1:0] last_detents;
  logic signed [COUNT_WIDTH-1:0] detents;
  logic                          edge_a;
  logic                          edge_b;
  logic                          cnt_step;
  logic                          cnt_up;

  assign edge_a = pin_a.level_old != pin_a.level_new;
  assign edge_b = pin_b.level_old != pin_b.level_new;

  // direction from the moving channel and the other channel's level; both moving is ignored
  always_comb begin
    cnt_step = 1'b0;
    cnt_up   = 1'b0;
    if (edge_a && !edge_b) begin
      cnt_step = 1'b1;
      cnt_up   = pin_a.level_new ^ pin_b.level_old;
    end else if (edge_b && !edge_a) begin
      cnt_step = 1'b1;
      cnt_up   = ~(pin_b.level_new ^ pin_a.level_old);
    end
  end

  // count wraps at its width
  always_comb begin
    count_next = count;
    if (cnt_step) begin
      count_next = cnt_up ? count + 1'b1 : count - 1'b1;
    end
  end

  // truncating signed division by a power of two
  assign detents = COUNT_WIDTH'(count_next / EDGES_PER_DETENT);

  assign mv.move = detents != last_detents;
  assign mv.up   = detents > last_detents;

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      last_detents <= '0;
    end else if (en) begin
      count        <= count_next;
      last_detents <= detents;
    end
  end

endmodule

`default_nettype wire

// ----- src/rept_position.sv -----
// position register: load or one step per detent change, wrapping or clamping at limits
// depends on rept_pkg
`default_nettype none

module rept_position (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                en,
  input  rept_pkg::detent_move_t                   mv,
  input  rept_pkg::pos_cfg_t                       cfg,
  input  wire logic                                load,
  input  wire logic signed [rept_pkg::POS_WIDTH-1:0] load_value,
  output logic signed [rept_pkg::POS_WIDTH-1:0]    position_next
);
  import rept_pkg::*;

  logic signed [POS_WIDTH-1:0] position;
  logic signed [POS_WIDTH:0]   step_ext;
  logic signed [POS_WIDTH:0]   sum;
  logic signed [POS_WIDTH:0]   min_ext;
  logic signed [POS_WIDTH:0]   max_ext;

  // one guard bit keeps the sum exact before limiting
  assign step_ext = $signed({2'b00, cfg.step});
  assign sum      = mv.up ? {position[POS_WIDTH-1], position} + step_ext
                          : {position[POS_WIDTH-1], position} - step_ext;
  assign min_ext  = {cfg.min_pos[POS_WIDTH-1], cfg.min_pos};
  assign max_ext  = {cfg.max_pos[POS_WIDTH-1], cfg.max_pos};

  // wrap checks the upper limit first, clamp the lower
  always_comb begin
    position_next = sum[POS_WIDTH-1:0];
    if (cfg.wrap) begin
      if (sum > max_ext) begin
        position_next = cfg.min_pos;
      end else if (sum < min_ext) begin
        position_next = cfg.max_pos;
      end
    end else begin
      if (sum < min_ext) begin
        position_next = cfg.min_pos;
      end else if (sum > max_ext) begin
        position_next = cfg.max_pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= START_POSITION_RST;
    end else if (load) begin
      position <= load_value;
    end else if (en && mv.move) begin
      position <= position_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/rotary_encoder_position_tracker_unit.sv -----
// Rotary encoder position tracker.
// Input stream: one beat per pin sample, s_axis_tdata[0] is channel A, [1] is channel B.
// Each pin is glitch filtered, filtered edges drive an x4 quadrature counter, and each
// change of the detent value (count divided by four, toward zero) steps the position by
// step_size, wrapping or clamping at the configured limits.
// Output stream: one beat per detent change, position in [15:0], encoder id in [23:16];
// samples without a detent change produce no beat.
// The result beat is valid in the cycle after the sample beat is accepted.
// Throughput: one sample per cycle unless the receiver stalls, set by the single output
// register; the filter, counter and position logic all finish within that cycle.
// When the receiver stalls with a beat waiting, s_axis_tready drops until it is taken.
// Reset (rst, synchronous) loads the register defaults, sets both filtered pins high,
// clears the counters and sets the position to start_position.
// Configuration over the APB port, registers at 4 * index; writing start_position also
// loads the position. Write registers only while the stream is idle.
// depends on rept_pkg, rept_glitch_filter, rept_quad_counter, rept_position
`default_nettype none

module rotary_encoder_position_tracker_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // sample stream: [0] clk_level, [1] dt_level
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  wire logic [rept_pkg::IN_WIDTH-1:0]       s_axis_tdata,
  // result stream: [15:0] position_out, [23:16] id_out
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  output logic [rept_pkg::OUT_WIDTH-1:0]           m_axis_tdata,
  // configuration port
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [rept_pkg::ADDR_WIDTH-1:0]     paddr,
  input  wire logic [rept_pkg::DATA_WIDTH-1:0]     pwdata,
  output logic [rept_pkg::DATA_WIDTH-1:0]          prdata,
  output logic                                     pready
);
  import rept_pkg::*;

  logic signed [POS_WIDTH-1:0] min_position;
  logic signed [POS_WIDTH-1:0] max_position;
  logic [STEP_WIDTH-1:0]       step_size;
  logic                        wrap_enable;
  logic [FILTER_WIDTH-1:0]     glitch_ticks;
  logic [ID_WIDTH-1:0]         encoder_id;
  logic signed [POS_WIDTH-1:0] start_position;

  logic         cfg_wr;
  reg_idx_t     cfg_idx;
  logic         start_load;
  logic         beat_in;
  pin_edge_t    pin_a;
  pin_edge_t    pin_b;
  detent_move_t mv;
  pos_cfg_t     pos_cfg;
  logic signed [POS_WIDTH-1:0] position_next;

  // configuration port
  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign cfg_idx    = reg_idx_t'(paddr[ADDR_WIDTH-1:2]);
  assign start_load = cfg_wr && (cfg_idx == REG_START_POSITION);

  always_ff @(posedge clk) begin
    if (rst) begin
      min_position   <= MIN_POSITION_RST;
      max_position   <= MAX_POSITION_RST;
      step_size      <= STEP_SIZE_RST;
      wrap_enable    <= WRAP_ENABLE_RST;
      glitch_ticks   <= GLITCH_TICKS_RST;
      encoder_id     <= ENCODER_ID_RST;
      start_position <= START_POSITION_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MIN_POSITION:   min_position   <= pwdata[POS_WIDTH-1:0];
        REG_MAX_POSITION:   max_position   <= pwdata[POS_WIDTH-1:0];
        REG_STEP_SIZE:      step_size      <= pwdata[STEP_WIDTH-1:0];
        REG_WRAP_ENABLE:    wrap_enable    <= pwdata[0];
        REG_GLITCH_TICKS:   glitch_ticks   <= pwdata[FILTER_WIDTH-1:0];
        REG_ENCODER_ID:     encoder_id     <= pwdata[ID_WIDTH-1:0];
        REG_START_POSITION: start_position <= pwdata[POS_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_MIN_POSITION:   prdata = DATA_WIDTH'(unsigned'(min_position));
      REG_MAX_POSITION:   prdata = DATA_WIDTH'(unsigned'(max_position));
      REG_STEP_SIZE:      prdata = DATA_WIDTH'(step_size);
      REG_WRAP_ENABLE:    prdata = DATA_WIDTH'(wrap_enable);
      REG_GLITCH_TICKS:   prdata = DATA_WIDTH'(glitch_ticks);
      REG_ENCODER_ID:     prdata = DATA_WIDTH'(encoder_id);
      REG_START_POSITION: prdata = DATA_WIDTH'(unsigned'(start_position));
      default:            prdata = '0;
    endcase
  end

  // a sample beat is taken whenever the output register is free or being emptied
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign beat_in       = s_axis_tvalid && s_axis_tready;

  rept_glitch_filter u_filt_a (
    .clk          (clk),
    .rst          (rst),
    .en           (beat_in),
    .sample       (s_axis_tdata[0]),
    .glitch_ticks (glitch_ticks),
    .pin          (pin_a)
  );

  rept_glitch_filter u_filt_b (
    .clk          (clk),
    .rst          (rst),
    .en           (beat_in),
    .sample       (s_axis_tdata[1]),
    .glitch_ticks (glitch_ticks),
    .pin          (pin_b)
  );

  rept_quad_counter u_counter (
    .clk   (clk),
    .rst   (rst),
    .en    (beat_in),
    .pin_a (pin_a),
    .pin_b (pin_b),
    .mv    (mv)
  );

  assign pos_cfg.min_pos = min_position;
  assign pos_cfg.max_pos = max_position;
  assign pos_cfg.step    = step_size;
  assign pos_cfg.wrap    = wrap_enable;

  rept_position u_position (
    .clk           (clk),
    .rst           (rst),
    .en            (beat_in),
    .mv            (mv),
    .cfg           (pos_cfg),
    .load          (start_load),
    .load_value    (pwdata[POS_WIDTH-1:0]),
    .position_next (position_next)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (beat_in) begin
      m_axis_tvalid <= mv.move;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (beat_in && mv.move) begin
      m_axis_tdata <= {encoder_id, position_next};
    end
  end

endmodule

`default_nettype wire
